[rtl/gbn_pkg.sv]
// shared types, constants and helpers for the go-back-n sender window
package gbn_pkg;

   // sequence space and window limits
   localparam int SEQ_BITS      = 7;
   localparam int SEQ_COUNT     = 1 << SEQ_BITS;
   localparam int SEQ_MAX       = SEQ_COUNT - 1;
   localparam int MAX_WINDOW    = 32;
   localparam int WIN_BITS      = $clog2(MAX_WINDOW + 1);
   localparam int ATT_BITS      = 4;
   localparam int ATTEMPT_MAX   = (1 << ATT_BITS) - 1;
   localparam int ATTEMPT_LIMIT = 10;
   localparam int ADDR_BITS     = 4;

   typedef logic [SEQ_BITS-1:0] seq_type;
   typedef logic [ATT_BITS-1:0] att_type;
   typedef logic [WIN_BITS-1:0] win_type;

   // event codes
   typedef enum logic [1:0] {
      OP_GEN     = 2'd0,
      OP_SEND    = 2'd1,
      OP_ACK     = 2'd2,
      OP_TIMEOUT = 2'd3
   } op_type;

   // result codes
   typedef enum logic [2:0] {
      KIND_TX     = 3'd0,
      KIND_RETX   = 3'd1,
      KIND_ACCEPT = 3'd2,
      KIND_REFUSE = 3'd3,
      KIND_ACK    = 3'd4,
      KIND_NONE   = 3'd5
   } kind_type;

   // register indexes
   typedef enum logic [1:0] {
      REG_WINDOW = 2'd0,
      REG_BUFFER = 2'd1,
      REG_LIMIT  = 2'd2
   } reg_index_type;

   // where an outgoing word comes from
   typedef enum logic [1:0] {
      SRC_PEND = 2'd0,
      SRC_SEND = 2'd1,
      SRC_RETX = 2'd2
   } emit_src_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_EMIT_ONE,
      ST_ACK_EMIT,
      ST_SEND,
      ST_RETX,
      ST_WALK_RD,
      ST_WALK_CHK
   } state_type;

   typedef struct packed {
      logic [1:0] operation;
      logic [6:0] event_seq;
   } req_word_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [6:0] out_seq;
      logic       last;
      logic       done_res;
   } rsp_word_type;

   typedef struct packed {
      logic [5:0]  window_size;
      logic [6:0]  buffer_size;
      logic [15:0] packet_limit;
   } cfg_type;

   // per-sequence bookkeeping held in the window memory
   typedef struct packed {
      logic    mark;
      att_type attempt;
   } entry_type;

   typedef struct packed {
      logic         load;
      logic         walk_read;
      logic         gen_commit;
      logic         ack_commit;
      logic         tmo_commit;
      logic         send_step;
      logic         retx_step;
      logic         base_step;
      logic         pend_load;
      kind_type     pend_kind;
      logic         emit;
      emit_src_type emit_src;
   } dp_cmd_type;

   typedef struct packed {
      op_type op;
      logic   stopped;
      logic   gen_ok;
      logic   send_ok;
      logic   ev_ok;
      logic   out_free;
      logic   send_more;
      logic   retx_more;
      logic   walk_more;
      logic   base_marked;
   } dp_sts_type;

   // forward distance modulo the sequence space
   function automatic seq_type seq_dist(seq_type from_seq, seq_type to_seq);
      return to_seq - from_seq;
   endfunction

endpackage

[rtl/go_back_n_sender_window.sv]
// Go-Back-N sender window engine: one event word in, one or more result words out.
// Events are handled one at a time; the input stalls from the cycle after a word is
// taken until the controller is back in idle. A generate, a refused or stray event, and
// a stopped event each give a single result word. A send slot gives one word per
// transmitted packet, a timeout one per retransmitted packet (at most 32). An accepted
// ack gives one word, then slides the window base over acknowledged sequences up to
// the first unacknowledged one or the next pointer, reading the 128-entry window
// memory one entry at a time. Stalls on the result side hold the emitting states.
module go_back_n_sender_window (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  gbn_pkg::req_word_type            req_word,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output gbn_pkg::rsp_word_type            rsp_word,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [gbn_pkg::ADDR_BITS-1:0]    paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);
   import gbn_pkg::*;

   cfg_type    cfg;
   dp_cmd_type cmd;
   dp_sts_type sts;

   // configuration registers
   gbn_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // event sequencer
   gbn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // window state and output register
   gbn_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_word  (req_word),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

[rtl/gbn_csr.sv]
// configuration registers behind the apb-style port
module gbn_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [gbn_pkg::ADDR_BITS-1:0]    paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready,
   output gbn_pkg::cfg_type                 cfg
);
   import gbn_pkg::*;

   logic [5:0]    window_ff, window_in;
   logic [6:0]    buffer_ff, buffer_in;
   logic [15:0]   limit_ff, limit_in;
   logic          wr_en;
   reg_index_type index;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;
   assign index  = reg_index_type'(paddr[ADDR_BITS-1:2]);

   // register write decode
   always_comb begin
      window_in = window_ff;
      buffer_in = buffer_ff;
      limit_in  = limit_ff;
      if (wr_en) begin
         unique case (index)
            REG_WINDOW: window_in = pwdata[5:0];
            REG_BUFFER: buffer_in = pwdata[6:0];
            REG_LIMIT:  limit_in  = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= 6'd8;
         buffer_ff <= 7'd64;
         limit_ff  <= 16'd1000;
      end else begin
         window_ff <= window_in;
         buffer_ff <= buffer_in;
         limit_ff  <= limit_in;
      end
   end

   // register read decode
   always_comb begin
      unique case (index)
         REG_WINDOW: prdata = {26'd0, window_ff};
         REG_BUFFER: prdata = {25'd0, buffer_ff};
         REG_LIMIT:  prdata = {16'd0, limit_ff};
         default:    prdata = 32'd0;
      endcase
   end

   assign cfg.window_size  = window_ff;
   assign cfg.buffer_size  = buffer_ff;
   assign cfg.packet_limit = limit_ff;

endmodule

[rtl/gbn_dpath.sv]
// window pointers, counters, per-sequence memory and output register
module gbn_dpath (
   input  logic                   clock,
   input  logic                   reset,
   input  gbn_pkg::cfg_type       cfg,
   input  gbn_pkg::req_word_type  req_word,
   input  gbn_pkg::dp_cmd_type    cmd,
   output gbn_pkg::dp_sts_type    sts,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output gbn_pkg::rsp_word_type  rsp_word
);
   import gbn_pkg::*;

   // every entry is written by a generate before any event can read it,
   // so the memory needs no clearing after reset
   entry_type    mem [SEQ_COUNT];
   entry_type    rd_ff;
   seq_type      rd_addr;
   logic         rd_en;
   logic         mem_we;
   seq_type      mem_wa;
   entry_type    mem_wd;

   op_type       op_ff, op_in;
   logic [6:0]   ev_ff, ev_in;
   seq_type      base_ff, base_in;
   seq_type      next_ff, next_in;
   seq_type      end_ff, end_in;
   seq_type      scan_ff, scan_in;
   logic [6:0]   unacked_ff, unacked_in;
   logic [15:0]  total_ff, total_in;
   logic         stopped_ff, stopped_in;
   kind_type     pend_kind_ff, pend_kind_in;
   seq_type      pend_seq_ff, pend_seq_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   seq_type      ev_addr;
   logic         ev_range;
   win_type      win;
   seq_type      next_inc;
   seq_type      scan_inc;
   att_type      att_new;
   logic [15:0]  total_new;

   // derived window values
   assign ev_addr  = SEQ_BITS'(ev_ff);
   assign ev_range = int'(ev_ff) < SEQ_COUNT;
   assign win      = (int'(cfg.window_size) < MAX_WINDOW) ?
                     WIN_BITS'(cfg.window_size) : WIN_BITS'(MAX_WINDOW);
   assign next_inc = next_ff + seq_type'(1);
   assign scan_inc = scan_ff + seq_type'(1);
   assign att_new  = (int'(rd_ff.attempt) == ATTEMPT_MAX) ?
                     rd_ff.attempt : rd_ff.attempt + att_type'(1);
   assign total_new = (total_ff == 16'hFFFF) ? total_ff : total_ff + 16'd1;

   // status toward the controller
   always_comb begin
      sts.op          = op_ff;
      sts.stopped     = stopped_ff;
      sts.gen_ok      = (int'(unacked_ff) < int'(cfg.buffer_size)) &&
                        (int'(seq_dist(base_ff, end_ff)) != SEQ_MAX);
      sts.send_ok     = (next_ff != end_ff) &&
                        (int'(seq_dist(base_ff, next_ff)) < int'(win));
      sts.send_more   = (next_inc != end_ff) &&
                        (int'(seq_dist(base_ff, next_inc)) < int'(win));
      sts.ev_ok       = ev_range && !rd_ff.mark &&
                        (seq_dist(base_ff, ev_addr) < seq_dist(base_ff, next_ff));
      sts.out_free    = !rsp_valid_ff || !rsp_stall;
      sts.retx_more   = scan_inc != next_ff;
      sts.walk_more   = base_ff != next_ff;
      sts.base_marked = rd_ff.mark;
   end

   // memory port control
   always_comb begin
      rd_en   = cmd.load | cmd.walk_read;
      rd_addr = cmd.walk_read ? base_ff : SEQ_BITS'(req_word.event_seq);
      mem_we  = 1'b0;
      mem_wa  = ev_addr;
      mem_wd  = '0;
      if (cmd.gen_commit) begin
         mem_we = 1'b1;
         mem_wa = end_ff;
         mem_wd = '0;
      end else if (cmd.send_step) begin
         mem_we = 1'b1;
         mem_wa = next_ff;
         mem_wd = '{mark: 1'b0, attempt: att_type'(1)};
      end else if (cmd.ack_commit) begin
         mem_we = 1'b1;
         mem_wd = '{mark: 1'b1, attempt: rd_ff.attempt};
      end else if (cmd.tmo_commit) begin
         mem_we = 1'b1;
         mem_wd = '{mark: 1'b0, attempt: att_new};
      end
   end

   // next values for pointers, counters and flags
   always_comb begin
      op_in      = op_ff;
      ev_in      = ev_ff;
      base_in    = base_ff;
      next_in    = next_ff;
      end_in     = end_ff;
      scan_in    = scan_ff;
      unacked_in = unacked_ff;
      total_in   = total_ff;
      stopped_in = stopped_ff;
      if (cmd.load) begin
         op_in      = op_type'(req_word.operation);
         ev_in      = req_word.event_seq;
         stopped_in = stopped_ff | (total_ff >= cfg.packet_limit);
      end
      if (cmd.gen_commit) begin
         end_in     = end_ff + seq_type'(1);
         unacked_in = unacked_ff + 7'd1;
      end
      if (cmd.send_step) begin
         next_in = next_inc;
      end
      if (cmd.ack_commit) begin
         unacked_in = (unacked_ff != 7'd0) ? unacked_ff - 7'd1 : unacked_ff;
         total_in   = total_new;
         stopped_in = stopped_ff | (total_new >= cfg.packet_limit);
      end
      if (cmd.tmo_commit) begin
         scan_in    = base_ff;
         stopped_in = stopped_ff | (int'(att_new) > ATTEMPT_LIMIT);
      end
      if (cmd.retx_step) begin
         scan_in = scan_inc;
      end
      if (cmd.base_step) begin
         base_in = base_ff + seq_type'(1);
      end
   end

   // single-word result waiting for the output register
   always_comb begin
      pend_kind_in = pend_kind_ff;
      pend_seq_in  = pend_seq_ff;
      if (cmd.pend_load) begin
         pend_kind_in = cmd.pend_kind;
         case (cmd.pend_kind)
            KIND_ACCEPT: pend_seq_in = end_ff;
            KIND_ACK:    pend_seq_in = ev_addr;
            default:     pend_seq_in = '0;
         endcase
      end
   end

   // output register
   always_comb begin
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_word_in.done_res = stopped_ff;
         unique case (cmd.emit_src)
            SRC_SEND: begin
               rsp_word_in.kind    = KIND_TX;
               rsp_word_in.out_seq = 7'(next_ff);
               rsp_word_in.last    = !sts.send_more;
            end
            SRC_RETX: begin
               rsp_word_in.kind    = KIND_RETX;
               rsp_word_in.out_seq = 7'(scan_ff);
               rsp_word_in.last    = !sts.retx_more;
            end
            default: begin
               rsp_word_in.kind    = pend_kind_ff;
               rsp_word_in.out_seq = 7'(pend_seq_ff);
               rsp_word_in.last    = 1'b1;
            end
         endcase
      end
   end

   // window memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      ev_ff        <= ev_in;
      scan_ff      <= scan_in;
      pend_kind_ff <= pend_kind_in;
      pend_seq_ff  <= pend_seq_in;
      rsp_word_ff  <= rsp_word_in;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         next_ff      <= '0;
         end_ff       <= '0;
         unacked_ff   <= '0;
         total_ff     <= '0;
         stopped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         next_ff      <= next_in;
         end_ff       <= end_in;
         unacked_ff   <= unacked_in;
         total_ff     <= total_in;
         stopped_ff   <= stopped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

`ifndef SYNTH
   // packets in flight never exceed the largest window
   a_inflight_bound: assert property (@(posedge clock) disable iff (reset)
      int'(seq_dist(base_ff, next_ff)) <= MAX_WINDOW)
      else $error("in-flight span exceeds window");

   // next pointer stays between base and end
   a_next_order: assert property (@(posedge clock) disable iff (reset)
      seq_dist(base_ff, next_ff) <= seq_dist(base_ff, end_ff))
      else $error("next pointer outside generated range");

   // retransmit scan starts at the window base
   a_scan_start: assert property (@(posedge clock) disable iff (reset)
      cmd.tmo_commit |=> scan_ff == base_ff)
      else $error("retransmit scan not at base");
`endif

endmodule

[rtl/gbn_ctrl.sv]
// event sequencer driving the window datapath
module gbn_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  gbn_pkg::dp_sts_type  sts,
   output gbn_pkg::dp_cmd_type  cmd
);
   import gbn_pkg::*;

   state_type state_ff, state_in;

   // next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.pend_kind = KIND_NONE;
      cmd.emit_src  = SRC_PEND;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.pend_load = 1'b1;
            state_in      = ST_EMIT_ONE;
            if (!sts.stopped) begin
               unique case (sts.op)
                  OP_GEN: begin
                     if (sts.gen_ok) begin
                        cmd.gen_commit = 1'b1;
                        cmd.pend_kind  = KIND_ACCEPT;
                     end else begin
                        cmd.pend_kind = KIND_REFUSE;
                     end
                  end
                  OP_SEND: begin
                     if (sts.send_ok) begin
                        state_in = ST_SEND;
                     end
                  end
                  OP_ACK: begin
                     if (sts.ev_ok) begin
                        cmd.ack_commit = 1'b1;
                        cmd.pend_kind  = KIND_ACK;
                        state_in       = ST_ACK_EMIT;
                     end
                  end
                  OP_TIMEOUT: begin
                     if (sts.ev_ok) begin
                        cmd.tmo_commit = 1'b1;
                        state_in       = ST_RETX;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_EMIT_ONE: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_ACK_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_WALK_RD;
            end
         end
         ST_SEND: begin
            if (sts.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_src  = SRC_SEND;
               cmd.send_step = 1'b1;
               if (!sts.send_more) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_RETX: begin
            if (sts.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_src  = SRC_RETX;
               cmd.retx_step = 1'b1;
               if (!sts.retx_more) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_WALK_RD: begin
            if (sts.walk_more) begin
               cmd.walk_read = 1'b1;
               state_in      = ST_WALK_CHK;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_WALK_CHK: begin
            if (sts.base_marked) begin
               cmd.base_step = 1'b1;
               state_in      = ST_WALK_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;

`ifndef SYNTH
   // a word is only pushed when the output register can take it
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_free)
      else $error("word pushed into full output register");

   // one memory write per cycle at most
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.gen_commit, cmd.send_step, cmd.ack_commit, cmd.tmo_commit}))
      else $error("conflicting memory writes");

   // mark check always follows its read
   a_walk_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK_CHK |-> $past(state_ff) == ST_WALK_RD)
      else $error("mark checked without a read");

   // a new event is taken only while idle
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> state_ff == ST_IDLE)
      else $error("event loaded while busy");
`endif

endmodule
